@@ rtl/iqas_pkg.sv @@
// ----------------------------------------------------------------------------
// iqas_pkg: shared types and constants for the issue queue age select block
// Beat layouts for both channels, operation codes, the entry layout held in
// the entry memory, and the default queue depth.
// ----------------------------------------------------------------------------
package iqas_pkg;

    // Default number of queue slots.
    localparam int QUEUE_DEPTH_DEF = 16;

    // Field widths fixed by the beat layouts.
    localparam int FUNC_W    = 2;
    localparam int SLOT_W    = 4;
    localparam int UNIT_W    = 3;
    localparam int AGE_W     = 16;
    localparam int PAYLOAD_W = 64;

    // Saturation value of an entry age.
    localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

    // Both source operands valid.
    localparam logic [1:0] READY_BOTH = 2'b11;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_FIND    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SELECT  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd3;

    // Input beat.
    typedef struct packed {
        logic [FUNC_W-1:0]    func;
        logic [SLOT_W-1:0]    slot;
        logic [UNIT_W-1:0]    unit;
        logic                 src1_ready;
        logic                 src2_ready;
        logic [AGE_W-1:0]     start_age;
        logic [PAYLOAD_W-1:0] payload;
    } iqas_in_t;

    // Result beat.
    typedef struct packed {
        logic                 found;
        logic [SLOT_W-1:0]    result_slot;
        logic [PAYLOAD_W-1:0] result_payload;
    } iqas_out_t;

    // Entry fields that are read and written back during a select.
    typedef struct packed {
        logic [UNIT_W-1:0] unit;
        logic [1:0]        ready;
        logic [AGE_W-1:0]  age;
    } iqas_meta_t;

endpackage

@@ rtl/issue_queue_age_select.sv @@
// ----------------------------------------------------------------------------
// issue_queue_age_select: issue queue with oldest-ready selection
// Find-free, write, select and release on a queue of QUEUE_DEPTH slots.
// Entry fields live in two RAMs; allocation bits are flip-flops.
//
//   Channel  Dir  Ports                      Beat
//   s_       in   s_valid, s_ready, s_data   iqas_in_t: one operation
//   m_       out  m_valid, m_ready, m_data   iqas_out_t: one result
//
// Write and release pass from acceptance through the response state to the result register.
// Find scans the allocation bits one slot per cycle and stops at the lowest free slot.
// Select walks the entry RAM one slot per cycle with read, age and write
// back, then reads the winning payload.
// Reset clears the allocation bits and control state; the RAMs need none.
// A new beat is taken once the result sits in the output register, even
// while m_ready is low; a full output register stalls only the next result.
// ----------------------------------------------------------------------------
module issue_queue_age_select
    import iqas_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  iqas_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output iqas_out_t m_data
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUEUE_DEPTH - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_RESP = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [FUNC_W-1:0]      op_reg, op_next;
    logic [UNIT_W-1:0]      unit_reg, unit_next;
    logic [CNT_W-1:0]       rd_idx_reg, rd_idx_next;
    logic                   chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]       chk_idx_reg, chk_idx_next;
    logic                   hit_reg, hit_next;
    logic [IDX_W-1:0]       best_idx_reg, best_idx_next;
    logic [AGE_W-1:0]       best_age_reg, best_age_next;
    logic                   res_found_reg, res_found_next;
    logic [IDX_W-1:0]       res_slot_reg, res_slot_next;
    logic                   res_pay_reg, res_pay_next;
    logic [QUEUE_DEPTH-1:0] alloc_reg, alloc_next;
    logic                   m_valid_reg, m_valid_next;
    iqas_out_t              m_data_reg, m_data_next;

    logic                   s_accept;
    logic                   slot_ok;
    logic [IDX_W-1:0]       slot_addr;
    logic [IDX_W-1:0]       scan_idx;
    logic [AGE_W-1:0]       aged;

    logic                   meta_we, meta_re;
    logic [IDX_W-1:0]       meta_waddr, meta_raddr;
    iqas_meta_t             meta_wdata, meta_rdata;
    logic                   pay_we, pay_re;
    logic [IDX_W-1:0]       pay_raddr;
    logic [PAYLOAD_W-1:0]   pay_rdata;

    // Entry unit, ready bits and age.
    iqas_ram #(
        .WIDTH ($bits(iqas_meta_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_meta_ram (
        .aclk  (aclk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .re    (meta_re),
        .raddr (meta_raddr),
        .rdata (meta_rdata)
    );

    // Entry payload.
    iqas_ram #(
        .WIDTH (PAYLOAD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_pay_ram (
        .aclk  (aclk),
        .we    (pay_we),
        .waddr (slot_addr),
        .wdata (s_data.payload),
        .re    (pay_re),
        .raddr (pay_raddr),
        .rdata (pay_rdata)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign slot_ok   = (32'(s_data.slot) < 32'(QUEUE_DEPTH));
    assign slot_addr = IDX_W'(s_data.slot);
    assign scan_idx  = rd_idx_reg[IDX_W-1:0];

    // Saturating age increment of the entry under check.
    assign aged = (meta_rdata.age == AGE_MAX) ? AGE_MAX : AGE_W'(meta_rdata.age + 1'b1);

    // Operation sequencer, scan datapath and result register.
    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        unit_next      = unit_reg;
        rd_idx_next    = rd_idx_reg;
        chk_vld_next   = 1'b0;
        chk_idx_next   = chk_idx_reg;
        hit_next       = hit_reg;
        best_idx_next  = best_idx_reg;
        best_age_next  = best_age_reg;
        res_found_next = res_found_reg;
        res_slot_next  = res_slot_reg;
        res_pay_next   = res_pay_reg;
        alloc_next     = alloc_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;

        meta_we    = 1'b0;
        meta_waddr = slot_addr;
        meta_wdata = '{unit: s_data.unit, ready: {s_data.src2_ready, s_data.src1_ready},
                       age: s_data.start_age};
        meta_re    = 1'b0;
        meta_raddr = scan_idx;
        pay_we     = 1'b0;
        pay_re     = 1'b0;
        pay_raddr  = best_idx_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    op_next        = s_data.func;
                    unit_next      = s_data.unit;
                    rd_idx_next    = '0;
                    hit_next       = 1'b0;
                    best_idx_next  = '0;
                    best_age_next  = '0;
                    res_found_next = 1'b0;
                    res_slot_next  = '0;
                    res_pay_next   = 1'b0;
                    case (s_data.func)
                        FUNC_FIND, FUNC_SELECT: begin
                            state_next = ST_SCAN;
                        end
                        FUNC_WRITE: begin
                            if (slot_ok) begin
                                alloc_next[slot_addr] = 1'b1;
                                meta_we               = 1'b1;
                                pay_we                = 1'b1;
                            end
                            state_next = ST_RESP;
                        end
                        FUNC_RELEASE: begin
                            if (slot_ok) begin
                                alloc_next[slot_addr] = 1'b0;
                            end
                            state_next = ST_RESP;
                        end
                        default: begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                if (op_reg == FUNC_FIND) begin
                    // Lowest free slot, one allocation bit per cycle.
                    if (!alloc_reg[scan_idx]) begin
                        res_found_next = 1'b1;
                        res_slot_next  = scan_idx;
                        state_next     = ST_RESP;
                    end else if (rd_idx_reg == CNT_LAST) begin
                        state_next = ST_RESP;
                    end else begin
                        rd_idx_next = rd_idx_reg + 1'b1;
                    end
                end else begin
                    // Read stage: fetch the next entry.
                    if (rd_idx_reg != CNT_END) begin
                        meta_re      = 1'b1;
                        chk_vld_next = 1'b1;
                        chk_idx_next = scan_idx;
                        rd_idx_next  = rd_idx_reg + 1'b1;
                    end
                    // Check stage: age the entry, write it back, track the oldest ready.
                    if (chk_vld_reg && alloc_reg[chk_idx_reg] && (meta_rdata.unit == unit_reg)) begin
                        meta_we    = 1'b1;
                        meta_waddr = chk_idx_reg;
                        meta_wdata = '{unit: meta_rdata.unit, ready: meta_rdata.ready, age: aged};
                        if ((meta_rdata.ready == READY_BOTH) && (!hit_reg || (aged > best_age_reg))) begin
                            hit_next      = 1'b1;
                            best_idx_next = chk_idx_reg;
                            best_age_next = aged;
                        end
                    end
                    // Scan done: fetch the winning payload.
                    if ((rd_idx_reg == CNT_END) && !chk_vld_reg) begin
                        pay_re         = hit_reg;
                        res_found_next = hit_reg;
                        res_slot_next  = best_idx_reg;
                        res_pay_next   = hit_reg;
                        state_next     = ST_RESP;
                    end
                end
            end

            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next               = 1'b1;
                    m_data_next.found          = res_found_reg;
                    m_data_next.result_slot    = SLOT_W'(res_slot_reg);
                    m_data_next.result_payload = res_pay_reg ? pay_rdata : '0;
                    state_next                 = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            chk_vld_reg <= 1'b0;
            alloc_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            chk_vld_reg <= chk_vld_next;
            alloc_reg   <= alloc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Operation context, scan datapath and result data.
    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        unit_reg      <= unit_next;
        rd_idx_reg    <= rd_idx_next;
        chk_idx_reg   <= chk_idx_next;
        hit_reg       <= hit_next;
        best_idx_reg  <= best_idx_next;
        best_age_reg  <= best_age_next;
        res_found_reg <= res_found_next;
        res_slot_reg  <= res_slot_next;
        res_pay_reg   <= res_pay_next;
        m_data_reg    <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // A write-back never lands on the entry being read in the same cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (meta_we && meta_re) |-> (meta_waddr != meta_raddr))
        else $error("entry RAM read and write hit the same slot");

    // The check stage always trails the read stage by exactly one slot.
    assert property (@(posedge aclk) disable iff (!aresetn)
        chk_vld_reg |-> ((CNT_W'(chk_idx_reg) + CNT_W'(1)) == rd_idx_reg))
        else $error("scan check stage out of step with read stage");

    // A found free slot really is free while its result is pending.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_RESP) && (op_reg == FUNC_FIND) && res_found_reg)
            |-> !alloc_reg[res_slot_reg])
        else $error("find returned an allocated slot");
`endif

endmodule

@@ rtl/iqas_ram.sv @@
// ----------------------------------------------------------------------------
// iqas_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered and holds
// its value in cycles without a read.
// ----------------------------------------------------------------------------
module iqas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ dv/issue_queue_age_select_tb.sv @@
// ----------------------------------------------------------------------------
// issue_queue_age_select_tb: self-checking bench for the age select queue
// Drives find, write, select and release beats with random gaps on both
// channels. A shadow copy of the queue predicts every result beat, and a
// small scoreboard compares each result, field by field, in order.
// ----------------------------------------------------------------------------
module issue_queue_age_select_tb;
    import iqas_pkg::*;

    localparam int DEPTH       = QUEUE_DEPTH_DEF;
    localparam int RANDOM_BEATS = 1500;
    localparam int DRAIN_CYCLES = DEPTH + 10;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int IN_W         = $bits(iqas_in_t);

    // Shadow of the queue contents plus the ordered list of results owed.
    class queue_shadow;
        logic             allocated [DEPTH];
        logic [UNIT_W-1:0] unit     [DEPTH];
        logic [1:0]        ready    [DEPTH];
        logic [AGE_W-1:0]  age      [DEPTH];
        logic [PAYLOAD_W-1:0] payload [DEPTH];
        iqas_out_t         owed_results [$];
        int                mismatches;

        function new();
            for (int i = 0; i < DEPTH; i++) begin
                allocated[i] = 1'b0;
            end
            mismatches = 0;
        endfunction

        // Applies one operation to the shadow queue and returns its result.
        function iqas_out_t apply_op(iqas_in_t beat);
            iqas_out_t res;
            logic      hit;
            int        best;
            logic [AGE_W-1:0] best_age;
            res = '0;
            hit = 1'b0;
            best = 0;
            best_age = '0;
            case (beat.func)
                FUNC_FIND: begin
                    for (int i = DEPTH - 1; i >= 0; i--) begin
                        if (!allocated[i]) begin
                            res.found = 1'b1;
                            res.result_slot = SLOT_W'(i);
                        end
                    end
                end
                FUNC_WRITE: begin
                    if (int'(beat.slot) < DEPTH) begin
                        allocated[beat.slot] = 1'b1;
                        unit[beat.slot]      = beat.unit;
                        ready[beat.slot]     = {beat.src2_ready, beat.src1_ready};
                        age[beat.slot]       = beat.start_age;
                        payload[beat.slot]   = beat.payload;
                    end
                end
                FUNC_SELECT: begin
                    // Age each entry of the unit in turn and track the oldest ready one.
                    for (int i = 0; i < DEPTH; i++) begin
                        if (allocated[i] && unit[i] == beat.unit) begin
                            if (age[i] != AGE_MAX) begin
                                age[i] = age[i] + 1'b1;
                            end
                            if (ready[i] == READY_BOTH && (!hit || age[i] > best_age)) begin
                                hit = 1'b1;
                                best = i;
                                best_age = age[i];
                            end
                        end
                    end
                    if (hit) begin
                        res.found = 1'b1;
                        res.result_slot = SLOT_W'(best);
                        res.result_payload = payload[best];
                    end
                end
                default: begin
                    if (int'(beat.slot) < DEPTH) begin
                        allocated[beat.slot] = 1'b0;
                    end
                end
            endcase
            return res;
        endfunction

        function void note_beat(iqas_in_t beat);
            owed_results.push_back(apply_op(beat));
        endfunction

        task report(string what);
            $display("[%0t] MISMATCH: %s", $realtime, what);
            mismatches++;
        endtask

        task check_beat(iqas_out_t got);
            iqas_out_t want;
            if (owed_results.size() == 0) begin
                report($sformatf("result beat with nothing owed: %p", got));
                return;
            end
            want = owed_results.pop_front();
            if (got.found !== want.found) begin
                report($sformatf("found got %b want %b", got.found, want.found));
            end
            if (got.result_slot !== want.result_slot) begin
                report($sformatf("result_slot got %0d want %0d",
                                 got.result_slot, want.result_slot));
            end
            if (got.result_payload !== want.result_payload) begin
                report($sformatf("result_payload got %h want %h",
                                 got.result_payload, want.result_payload));
            end
        endtask

        function int owed();
            return owed_results.size();
        endfunction
    endclass

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    iqas_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    iqas_out_t m_data;

    queue_shadow sb = new();
    logic        burst = 1'b0;
    int          cycles = 0;

    issue_queue_age_select #(.QUEUE_DEPTH(DEPTH)) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Guard against a hung handshake.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Every accepted result beat goes to the scoreboard.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_beat(m_data);
        end
    end

    // Result side: a random stall before each beat, none during bursts.
    initial begin
        int stall;
        wait (aresetn);
        forever begin
            stall = burst ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Sends one beat after a random gap and records it once accepted.
    task automatic drive_beat(input iqas_in_t beat);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        sb.note_beat(beat);
    endtask

    // Fully random beat, then the operation, slot and unit forced.
    function automatic iqas_in_t op_beat(logic [FUNC_W-1:0] func,
                                         logic [SLOT_W-1:0] slot,
                                         logic [UNIT_W-1:0] unit);
        iqas_in_t beat;
        beat = IN_W'({$urandom, $urandom, $urandom});
        beat.func = func;
        beat.slot = slot;
        beat.unit = unit;
        return beat;
    endfunction

    function automatic iqas_in_t write_beat(logic [SLOT_W-1:0] slot,
                                            logic [UNIT_W-1:0] unit,
                                            logic [1:0] rdy,
                                            logic [AGE_W-1:0] start_age,
                                            logic [PAYLOAD_W-1:0] data);
        iqas_in_t beat;
        beat = op_beat(FUNC_WRITE, slot, unit);
        beat.src1_ready = rdy[0];
        beat.src2_ready = rdy[1];
        beat.start_age  = start_age;
        beat.payload    = data;
        return beat;
    endfunction

    // Picks a slot whose allocation bit matches want_alloc, or any slot.
    function automatic logic [SLOT_W-1:0] pick_slot(logic want_alloc);
        int hits [$];
        for (int i = 0; i < DEPTH; i++) begin
            if (sb.allocated[i] == want_alloc) begin
                hits.push_back(i);
            end
        end
        if (hits.size() == 0 || $urandom_range(0, 9) < 3) begin
            return SLOT_W'($urandom_range(0, DEPTH - 1));
        end
        return SLOT_W'(hits[$urandom_range(0, hits.size() - 1)]);
    endfunction

    // Mostly well-formed traffic: writes to free slots, selects for live
    // units and releases of live slots, with ages sometimes near saturation.
    function automatic iqas_in_t random_beat();
        iqas_in_t beat;
        int       roll;
        int       pick;
        roll = $urandom_range(0, 99);
        if (roll < 15) begin
            beat = op_beat(FUNC_FIND, 4'($urandom), 3'($urandom));
        end else if (roll < 50) begin
            beat = op_beat(FUNC_WRITE, pick_slot(1'b0), 3'($urandom));
            if ($urandom_range(0, 2) != 0) begin
                {beat.src2_ready, beat.src1_ready} = READY_BOTH;
            end
            case ($urandom_range(0, 7))
                0: beat.start_age = AGE_MAX - AGE_W'($urandom_range(0, 3));
                1: beat.start_age = '0;
                2: beat.start_age = AGE_W'($urandom_range(0, 20));
                default: ;
            endcase
        end else if (roll < 82) begin
            beat = op_beat(FUNC_SELECT, 4'($urandom), 3'($urandom));
            pick = $urandom_range(0, DEPTH - 1);
            if (sb.allocated[pick] && $urandom_range(0, 9) < 8) begin
                beat.unit = sb.unit[pick];
            end
        end else begin
            beat = op_beat(FUNC_RELEASE, pick_slot(1'b1), 3'($urandom));
        end
        return beat;
    endfunction

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty queue, saturation ties, not-ready entries,
        // overwrite, release of a free slot and a full queue.
        drive_beat(op_beat(FUNC_FIND, 4'hF, 3'd7));
        drive_beat(op_beat(FUNC_SELECT, 4'hF, 3'd3));
        drive_beat(write_beat(4'd0, 3'd0, 2'b11, AGE_MAX - 1'b1, '1));
        drive_beat(write_beat(4'd1, 3'd0, 2'b11, AGE_MAX, '0));
        drive_beat(op_beat(FUNC_SELECT, 4'd0, 3'd0));
        drive_beat(write_beat(4'd15, 3'd7, 2'b01, '0, 64'h0123_4567_89AB_CDEF));
        drive_beat(write_beat(4'd14, 3'd7, 2'b10, 16'd100, 64'hFEDC_BA98_7654_3210));
        drive_beat(op_beat(FUNC_SELECT, 4'd0, 3'd7));
        drive_beat(write_beat(4'd13, 3'd7, 2'b11, 16'd5, 64'hA5A5_A5A5_5A5A_5A5A));
        drive_beat(op_beat(FUNC_SELECT, 4'd0, 3'd7));
        drive_beat(write_beat(4'd13, 3'd7, 2'b11, '0, 64'h8000_0000_0000_0001));
        drive_beat(op_beat(FUNC_RELEASE, 4'd1, 3'd0));
        drive_beat(op_beat(FUNC_RELEASE, 4'd1, 3'd0));
        drive_beat(op_beat(FUNC_FIND, 4'd0, 3'd0));
        for (int i = 1; i <= 12; i++) begin
            drive_beat(write_beat(SLOT_W'(i), 3'($urandom), 2'($urandom),
                                  16'($urandom), {$urandom, $urandom}));
        end
        drive_beat(op_beat(FUNC_FIND, 4'd0, 3'd0));
        drive_beat(op_beat(FUNC_SELECT, 4'd0, 3'd7));
        drive_beat(op_beat(FUNC_RELEASE, 4'd0, 3'd0));

        // Random traffic, switching now and then into gap-free bursts.
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 50 == 0) begin
                burst = ($urandom_range(0, 3) == 0);
            end
            drive_beat(random_beat());
        end
        s_valid <= 1'b0;

        // Drain every owed result, then watch for stray beats.
        while (sb.owed() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/iqas_pkg.sv
rtl/iqas_ram.sv
rtl/issue_queue_age_select.sv
dv/issue_queue_age_select_tb.sv
